// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the evaluation unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/spe_pkg.sv -----
// ----------------------------------------------------------------------------
// Spline position evaluator package
// Word types, codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package spe_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int DW             = 42;
   localparam int PW             = DW + 18;
   localparam int CSR_IW         = 2;
   localparam int CSR_DW         = 7;
   localparam int ROUND_HALF     = 32768;

   localparam logic [16:0] T_ONE = 17'h10000;

   localparam logic OP_EVAL  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic STATUS_POS   = 1'b0;
   localparam logic STATUS_WRITE = 1'b1;

   localparam logic [CSR_IW-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_LOOP_MODE   = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_CURVE_TYPE  = 2'd2;

   typedef enum logic [1:0] {
      CURVE_LINEAR  = 2'd0,
      CURVE_BEZIER  = 2'd1,
      CURVE_CATMULL = 2'd2
   } curve_type_type;

   typedef struct packed {
      logic               opcode;
      logic [16:0]        param_t;
      logic [5:0]         point_index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [5:0]         segment_index;
      logic [16:0]        local_t;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic           op;
      curve_type_type ctype;
      logic [5:0]     seg;
      logic [16:0]    lt;
   } ctl_type;

   typedef logic signed [DW-1:0] dval_type;
   typedef logic signed [PW-1:0] prod_type;

   localparam dval_type SAT_HI = {{(DW-31){1'b0}}, {31{1'b1}}};
   localparam dval_type SAT_LO = {{(DW-31){1'b1}}, 31'b0};

   function automatic dval_type round_q16(input prod_type v);
      prod_type s;
      s = v + PW'(ROUND_HALF);
      return s[DW+15:16];
   endfunction

   function automatic logic [31:0] sat32(input dval_type v);
      logic [31:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[31:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic dval_type coord(input logic [95:0] w, input int unsigned a);
      logic signed [31:0] c;
      c = w[95 - 32*a -: 32];
      return DW'(c);
   endfunction

endpackage

// ----- rtl/spline_position_eval_unit.sv -----
// Each accepted request word yields one response word, in order.
// Throughput: one word per cycle; each stage holds under backpressure.
// Point reads use four copies of the point store, one read port each.
// Reset clears stage valid bits and the configuration registers.
// The point store has no reset and no clearing pass; entries are undefined until written.
// ----------------------------------------------------------------------------
// Spline position evaluation unit
// Eleven-stage pipeline: segment select, point fetch, end extrapolation,
// coefficient setup, three multiply/round levels and saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spline_position_eval_unit #(
   parameter int MAX_POINTS = spe_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  spe_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output spe_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [spe_pkg::CSR_IW-1:0]    csr_index,
   input  logic [spe_pkg::CSR_DW-1:0]    csr_wdata
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int NSTG = 11;
   localparam int DW   = spe_pkg::DW;
   localparam int PW   = spe_pkg::PW;

   logic [6:0] point_count_ff;
   logic       loop_mode_ff;
   logic [1:0] curve_type_ff;

   logic [NSTG:1] v_ff;
   logic [NSTG:1] v_in;
   logic [NSTG:1] en;

   // stage 1
   spe_pkg::req_type s1_req_ff;
   logic [23:0]      s1_scaled_ff, s1_scaled_in;
   logic [6:0]       s1_n_ff, s1_n_in;
   logic [6:0]       s1_nseg_ff, s1_nseg_in;
   logic [16:0]      t_clamp;

   // stage 2
   spe_pkg::ctl_type ctl_ff [2:10];
   spe_pkg::ctl_type ctl_b_in;
   logic             s2_ext0_ff, s2_ext0_in;
   logic             s2_ext3_ff, s2_ext3_in;
   logic             s2_many_ff, s2_many_in;
   logic             s2_zero_ff, s2_zero_in;
   logic [7:0]       idx_b [4];
   logic [7:0]       seg_raw;
   logic [6:0]       seg_b;
   logic [7:0]       seg_p2;
   logic [95:0]      rd_data [4];
   logic             ram_we;

   // datapath
   spe_pkg::dval_type p_ff     [4][3];
   spe_pkg::dval_type p_in     [4][3];
   spe_pkg::dval_type base1_ff [3][3];
   spe_pkg::dval_type base1_in [3][3];
   spe_pkg::dval_type x1_ff    [3][3];
   spe_pkg::dval_type x1_in    [3][3];
   spe_pkg::dval_type auxb_ff  [4:6][3];
   spe_pkg::dval_type auxb_in  [3];
   spe_pkg::dval_type auxa_ff  [4:8][3];
   spe_pkg::dval_type auxa_in  [3];
   spe_pkg::prod_type prod1_ff [3][3];
   spe_pkg::prod_type prod1_in [3][3];
   spe_pkg::dval_type base1m_ff[3][3];
   spe_pkg::dval_type q1_ff    [3][3];
   spe_pkg::dval_type q1_in    [3][3];
   spe_pkg::prod_type prod2_ff [3][2];
   spe_pkg::prod_type prod2_in [3][2];
   spe_pkg::dval_type base2_ff [3][2];
   spe_pkg::dval_type base2_in [3][2];
   spe_pkg::dval_type q2_ff    [3][2];
   spe_pkg::dval_type q2_in    [3][2];
   spe_pkg::prod_type prod3_ff [3];
   spe_pkg::prod_type prod3_in [3];
   spe_pkg::dval_type base3_ff [3];
   spe_pkg::dval_type base3_in [3];
   spe_pkg::dval_type q3_ff    [3];
   spe_pkg::dval_type q3_in    [3];
   spe_pkg::rsp_type  rsp_ff, rsp_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 7'd0;
         loop_mode_ff   <= 1'b0;
         curve_type_ff  <= spe_pkg::CURVE_CATMULL;
      end else if (csr_we) begin
         case (csr_index)
            spe_pkg::CSR_POINT_COUNT: point_count_ff <= csr_wdata[6:0];
            spe_pkg::CSR_LOOP_MODE:   loop_mode_ff   <= csr_wdata[0];
            spe_pkg::CSR_CURVE_TYPE:  curve_type_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // handshake and valid chain
   always_comb begin
      en[NSTG] = !v_ff[NSTG] || rsp_ready;
      for (int i = NSTG - 1; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[1] = req_valid;
      for (int i = 2; i <= NSTG; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 1; i <= NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = v_ff[NSTG];
   assign rsp_data  = rsp_ff;

   // stage 1: clamp t, scale by segment count
   always_comb begin
      if (32'(point_count_ff) > MAX_POINTS) begin
         s1_n_in = 7'(MAX_POINTS);
      end else begin
         s1_n_in = point_count_ff;
      end
      t_clamp      = (req_data.param_t > spe_pkg::T_ONE) ? spe_pkg::T_ONE : req_data.param_t;
      s1_nseg_in   = loop_mode_ff ? s1_n_in : s1_n_in - 7'd1;
      s1_scaled_in = {7'b0, t_clamp} * {17'b0, s1_nseg_in};
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_req_ff    <= req_data;
         s1_scaled_ff <= s1_scaled_in;
         s1_n_ff      <= s1_n_in;
         s1_nseg_ff   <= s1_nseg_in;
      end
   end

   // stage 2: segment, neighbor indices, point fetch
   always_comb begin
      seg_raw    = s1_scaled_ff[23:16];
      s2_many_in = s1_n_ff >= 7'd2;
      s2_zero_in = s1_n_ff == 7'd0;
      ctl_b_in.op = s1_req_ff.opcode;
      if (!s2_many_in) begin
         seg_b       = 7'd0;
         ctl_b_in.lt = 17'd0;
      end else if ({1'b0, s1_nseg_ff} <= seg_raw) begin
         seg_b       = s1_nseg_ff - 7'd1;
         ctl_b_in.lt = spe_pkg::T_ONE;
      end else begin
         seg_b       = seg_raw[6:0];
         ctl_b_in.lt = {1'b0, s1_scaled_ff[15:0]};
      end
      ctl_b_in.seg = seg_b[5:0];
      if (!s2_many_in) begin
         ctl_b_in.ctype = spe_pkg::CURVE_LINEAR;
      end else begin
         case (curve_type_ff)
            spe_pkg::CURVE_LINEAR: ctl_b_in.ctype = spe_pkg::CURVE_LINEAR;
            spe_pkg::CURVE_BEZIER: ctl_b_in.ctype = spe_pkg::CURVE_BEZIER;
            default:               ctl_b_in.ctype = spe_pkg::CURVE_CATMULL;
         endcase
      end
      seg_p2   = {1'b0, seg_b} + 8'd2;
      idx_b[1] = {1'b0, seg_b};
      if (loop_mode_ff) begin
         idx_b[0] = (seg_b == 7'd0) ? {1'b0, s1_n_ff} - 8'd1 : {1'b0, seg_b} - 8'd1;
         idx_b[2] = ({1'b0, seg_b} + 8'd1 == {1'b0, s1_n_ff}) ? 8'd0
                                                              : {1'b0, seg_b} + 8'd1;
         idx_b[3] = (seg_p2 >= {1'b0, s1_n_ff}) ? seg_p2 - {1'b0, s1_n_ff} : seg_p2;
      end else begin
         idx_b[0] = {1'b0, seg_b} - 8'd1;
         idx_b[2] = {1'b0, seg_b} + 8'd1;
         idx_b[3] = seg_p2;
      end
      s2_ext0_in = !loop_mode_ff && (seg_b == 7'd0);
      s2_ext3_in = !loop_mode_ff && (seg_p2 >= {1'b0, s1_n_ff});
      ram_we     = en[2] && v_ff[1] && (s1_req_ff.opcode == spe_pkg::OP_WRITE) &&
                   (32'(s1_req_ff.point_index) < MAX_POINTS);
   end

   for (genvar g = 0; g < 4; g++) begin : g_store
      spe_ram #(
         .WIDTH (96),
         .DEPTH (MAX_POINTS)
      ) u_store (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (AW'(s1_req_ff.point_index)),
         .wr_data ({s1_req_ff.point_x, s1_req_ff.point_y, s1_req_ff.point_z}),
         .rd_en   (en[2]),
         .rd_addr (AW'(idx_b[g])),
         .rd_data (rd_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ctl_ff[2]  <= ctl_b_in;
         s2_ext0_ff <= s2_ext0_in;
         s2_ext3_ff <= s2_ext3_in;
         s2_many_ff <= s2_many_in;
         s2_zero_ff <= s2_zero_in;
      end
      for (int i = 3; i <= 10; i++) begin
         if (en[i]) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // stage 3: open-end extrapolation
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         p_in[1][a] = spe_pkg::coord(rd_data[1], a);
         p_in[2][a] = s2_many_ff ? spe_pkg::coord(rd_data[2], a) : p_in[1][a];
         p_in[0][a] = s2_ext0_ff ? (p_in[1][a] <<< 1) - p_in[2][a]
                                 : spe_pkg::coord(rd_data[0], a);
         p_in[3][a] = s2_ext3_ff ? (p_in[2][a] <<< 1) - p_in[1][a]
                                 : spe_pkg::coord(rd_data[3], a);
         if (s2_zero_ff) begin
            for (int k = 0; k < 4; k++) begin
               p_in[k][a] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         p_ff <= p_in;
      end
   end

   // stage 4: first-level operands
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            base1_in[a][k] = '0;
            x1_in[a][k]    = '0;
         end
         auxb_in[a] = '0;
         auxa_in[a] = '0;
         case (ctl_ff[3].ctype)
            spe_pkg::CURVE_LINEAR: begin
               base1_in[a][0] = p_ff[1][a];
               x1_in[a][0]    = p_ff[2][a] - p_ff[1][a];
            end
            spe_pkg::CURVE_BEZIER: begin
               for (int k = 0; k < 3; k++) begin
                  base1_in[a][k] = p_ff[k][a];
                  x1_in[a][k]    = p_ff[k+1][a] - p_ff[k][a];
               end
            end
            default: begin
               base1_in[a][0] = (p_ff[0][a] <<< 1) - ((p_ff[1][a] <<< 2) + p_ff[1][a])
                              + (p_ff[2][a] <<< 2) - p_ff[3][a];
               x1_in[a][0]    = ((p_ff[1][a] <<< 1) + p_ff[1][a]) - p_ff[0][a]
                              - ((p_ff[2][a] <<< 1) + p_ff[2][a]) + p_ff[3][a];
               auxb_in[a]     = p_ff[2][a] - p_ff[0][a];
               auxa_in[a]     = p_ff[1][a] <<< 1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         base1_ff   <= base1_in;
         x1_ff      <= x1_in;
         auxb_ff[4] <= auxb_in;
         auxa_ff[4] <= auxa_in;
      end
      for (int i = 5; i <= 6; i++) begin
         if (en[i]) begin
            auxb_ff[i] <= auxb_ff[i-1];
         end
      end
      for (int i = 5; i <= 8; i++) begin
         if (en[i]) begin
            auxa_ff[i] <= auxa_ff[i-1];
         end
      end
   end

   // stage 5: first multiply
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            prod1_in[a][k] = PW'(x1_ff[a][k]) * PW'($signed({1'b0, ctl_ff[4].lt}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         prod1_ff  <= prod1_in;
         base1m_ff <= base1_ff;
      end
   end

   // stage 6: first round and add
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            q1_in[a][k] = base1m_ff[a][k] + spe_pkg::round_q16(prod1_ff[a][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         q1_ff <= q1_in;
      end
   end

   // stage 7: second operands and multiply
   always_comb begin
      spe_pkg::dval_type x2 [3][2];
      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < 2; j++) begin
            x2[a][j]       = '0;
            base2_in[a][j] = '0;
         end
         case (ctl_ff[6].ctype)
            spe_pkg::CURVE_LINEAR: begin
               base2_in[a][0] = q1_ff[a][0];
            end
            spe_pkg::CURVE_BEZIER: begin
               for (int j = 0; j < 2; j++) begin
                  base2_in[a][j] = q1_ff[a][j];
                  x2[a][j]       = q1_ff[a][j+1] - q1_ff[a][j];
               end
            end
            default: begin
               base2_in[a][0] = auxb_ff[6][a];
               x2[a][0]       = q1_ff[a][0];
            end
         endcase
         for (int j = 0; j < 2; j++) begin
            prod2_in[a][j] = PW'(x2[a][j]) * PW'($signed({1'b0, ctl_ff[6].lt}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         prod2_ff <= prod2_in;
         base2_ff <= base2_in;
      end
   end

   // stage 8: second round and add
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < 2; j++) begin
            q2_in[a][j] = base2_ff[a][j] + spe_pkg::round_q16(prod2_ff[a][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         q2_ff <= q2_in;
      end
   end

   // stage 9: third operands and multiply
   always_comb begin
      spe_pkg::dval_type x3 [3];
      for (int a = 0; a < 3; a++) begin
         case (ctl_ff[8].ctype)
            spe_pkg::CURVE_LINEAR: begin
               base3_in[a] = q2_ff[a][0];
               x3[a]       = '0;
            end
            spe_pkg::CURVE_BEZIER: begin
               base3_in[a] = q2_ff[a][0];
               x3[a]       = q2_ff[a][1] - q2_ff[a][0];
            end
            default: begin
               base3_in[a] = auxa_ff[8][a];
               x3[a]       = q2_ff[a][0];
            end
         endcase
         prod3_in[a] = PW'(x3[a]) * PW'($signed({1'b0, ctl_ff[8].lt}));
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         prod3_ff <= prod3_in;
         base3_ff <= base3_in;
      end
   end

   // stage 10: third round and add
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         q3_in[a] = base3_ff[a] + spe_pkg::round_q16(prod3_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[10]) begin
         q3_ff <= q3_in;
      end
   end

   // stage 11: halve (Catmull-Rom only), saturate, build response word
   always_comb begin
      spe_pkg::dval_type fin [3];
      spe_pkg::dval_type inc;
      for (int a = 0; a < 3; a++) begin
         inc = q3_ff[a] + DW'(1);
         if (ctl_ff[10].ctype == spe_pkg::CURVE_CATMULL) begin
            fin[a] = {inc[DW-1], inc[DW-1:1]};
         end else begin
            fin[a] = q3_ff[a];
         end
      end
      if (ctl_ff[10].op == spe_pkg::OP_WRITE) begin
         rsp_in               = '0;
         rsp_in.status        = spe_pkg::STATUS_WRITE;
      end else begin
         rsp_in.pos_x         = spe_pkg::sat32(fin[0]);
         rsp_in.pos_y         = spe_pkg::sat32(fin[1]);
         rsp_in.pos_z         = spe_pkg::sat32(fin[2]);
         rsp_in.segment_index = ctl_ff[10].seg;
         rsp_in.local_t       = ctl_ff[10].lt;
         rsp_in.status        = spe_pkg::STATUS_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (en[11]) begin
         rsp_ff <= rsp_in;
      end
   end

   `SPE_ASSERT_IMP(a_stall_full, clock, reset, !req_ready, &v_ff, "stall with a bubble")
   `SPE_ASSERT_IMP(a_lt_range, clock, reset, rsp_valid, rsp_data.local_t <= spe_pkg::T_ONE,
                   "local t above one")
   `SPE_ASSERT_IMP(a_write_zero, clock, reset,
                   rsp_valid && rsp_data.status == spe_pkg::STATUS_WRITE,
                   rsp_data.pos_x == 32'sd0 && rsp_data.local_t == 17'd0 &&
                   rsp_data.segment_index == 6'd0, "write word with payload")

endmodule

// ----- rtl/spe_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spe_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
